// ===== design/dsu_pkg.sv =====
// ----------------------------------------------------------------------------
// dsu_pkg
// Shared widths, opcodes and status codes of the disjoint-set table.
// ----------------------------------------------------------------------------
package dsu_pkg;

    // Payload field widths
    localparam int OP_W     = 2;
    localparam int NODE_W   = 8;
    localparam int SET_W    = 9;
    localparam int STATUS_W = 2;
    localparam int RANK_W   = 4;

    // Default table depth
    localparam int NODE_COUNT_DEF = 256;

    // Rank saturates here
    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

    // Opcodes
    localparam logic [OP_W-1:0] OP_MAKE  = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND  = 2'd1;
    localparam logic [OP_W-1:0] OP_UNION = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;

endpackage

// ===== design/dsu_if.sv =====
// ----------------------------------------------------------------------------
// dsu_in_if / dsu_out_if
// Valid/ready channels for request and result beats.
// ----------------------------------------------------------------------------
interface dsu_in_if;
    logic                        valid;
    logic                        ready;
    logic [dsu_pkg::OP_W-1:0]    opcode;
    logic [dsu_pkg::NODE_W-1:0]  node_a;
    logic [dsu_pkg::NODE_W-1:0]  node_b;

    modport source (output valid, output opcode, output node_a, output node_b,
                    input ready);
    modport sink   (input valid, input opcode, input node_a, input node_b,
                    output ready);
endinterface

interface dsu_out_if;
    logic                          valid;
    logic                          ready;
    logic [dsu_pkg::NODE_W-1:0]    node_out;
    logic [dsu_pkg::SET_W-1:0]     set_count;
    logic [dsu_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output node_out, output set_count, output status,
                    input ready);
    modport sink   (input valid, input node_out, input set_count, input status,
                    output ready);
endinterface

// ===== design/disjoint_set_union_by_rank_top.sv =====
// ----------------------------------------------------------------------------
// disjoint_set_union_by_rank_top
// Union-find table with union by rank, no path compression.
//
// req carries opcode, node_a, node_b; rsp returns one beat per request with
// node_out, set_count and status. A request is taken only when the engine is
// idle; one request is processed at a time.
// From request to result register: make and rejected requests go from decode
// straight to the output state; find first walks node_a to its root and union
// walks node_a, then node_b. A walk takes at most log2 of the node count parent
// hops to the root, set by rank. Each hop is one read of the parent memory,
// whose registered output sets the walk rate of one link per cycle.
// The next request is accepted in the cycle after the result is loaded.
// Reset clears the node and set counters; the memories are not cleared, since
// an entry is only read after make has written it.
// The result sits in an output register: a stalled rsp holds it there, the
// next request may still be accepted and walked, and its result waits until
// the register is free.
// ----------------------------------------------------------------------------
module disjoint_set_union_by_rank_top #(
    parameter int NODE_COUNT = dsu_pkg::NODE_COUNT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    dsu_in_if.sink       req,
    dsu_out_if.source    rsp
);

    localparam int IDX_W  = $clog2(NODE_COUNT);
    localparam int CNT_W  = $clog2(NODE_COUNT + 1);
    localparam int CMP_W  = (CNT_W > dsu_pkg::NODE_W) ? CNT_W : dsu_pkg::NODE_W;
    localparam int RANK_W = dsu_pkg::RANK_W;

    // FSM codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_WALK_A = 3'd2;
    localparam logic [2:0] S_WALK_B = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    // Control state
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] alloc_reg, alloc_next;
    logic [CNT_W-1:0] live_reg,  live_next;
    logic             out_valid_reg, out_valid_next;

    // Working payload
    logic [dsu_pkg::OP_W-1:0]     op_reg, op_next;
    logic [dsu_pkg::NODE_W-1:0]   a_reg, a_next;
    logic [dsu_pkg::NODE_W-1:0]   b_reg, b_next;
    logic [IDX_W-1:0]             cur_reg, cur_next;
    logic [IDX_W-1:0]             root_a_reg, root_a_next;
    logic [RANK_W-1:0]            rank_a_reg, rank_a_next;
    logic [dsu_pkg::NODE_W-1:0]   res_node_reg, res_node_next;
    logic [dsu_pkg::STATUS_W-1:0] res_status_reg, res_status_next;

    // Output register
    logic [dsu_pkg::NODE_W-1:0]   out_node_reg, out_node_next;
    logic [dsu_pkg::SET_W-1:0]    out_count_reg, out_count_next;
    logic [dsu_pkg::STATUS_W-1:0] out_status_reg, out_status_next;

    // Memory ports
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  rd_parent;
    logic [RANK_W-1:0] rd_rank;
    logic              par_we;
    logic [IDX_W-1:0]  par_addr;
    logic [IDX_W-1:0]  par_data;
    logic              rank_we;
    logic [IDX_W-1:0]  rank_addr;
    logic [RANK_W-1:0] rank_data;

    logic a_bad;
    logic b_bad;
    logic out_load;

    dsu_store #(
        .NODE_COUNT (NODE_COUNT)
    ) u_store (
        .clk       (clk),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_parent (rd_parent),
        .rd_rank   (rd_rank),
        .par_we    (par_we),
        .par_addr  (par_addr),
        .par_data  (par_data),
        .rank_we   (rank_we),
        .rank_addr (rank_addr),
        .rank_data (rank_data)
    );

    // Range checks against the allocation count
    assign a_bad = CMP_W'(a_reg) >= CMP_W'(alloc_reg);
    assign b_bad = CMP_W'(b_reg) >= CMP_W'(alloc_reg);

    // Handshakes
    assign req.ready     = (state_reg == S_IDLE);
    assign out_load      = (state_reg == S_OUT) && (!out_valid_reg || rsp.ready);
    assign rsp.valid     = out_valid_reg;
    assign rsp.node_out  = out_node_reg;
    assign rsp.set_count = out_count_reg;
    assign rsp.status    = out_status_reg;

    // Sequencer: decode, walk root of a, walk root of b, link
    always_comb
    begin
        state_next      = state_reg;
        alloc_next      = alloc_reg;
        live_next       = live_reg;
        op_next         = op_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        cur_next        = cur_reg;
        root_a_next     = root_a_reg;
        rank_a_next     = rank_a_reg;
        res_node_next   = res_node_reg;
        res_status_next = res_status_reg;
        rd_en           = 1'b0;
        rd_addr         = cur_reg;
        par_we          = 1'b0;
        par_addr        = cur_reg;
        par_data        = cur_reg;
        rank_we         = 1'b0;
        rank_addr       = cur_reg;
        rank_data       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.opcode;
                    a_next     = req.node_a;
                    b_next     = req.node_b;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_node_next   = '0;
                res_status_next = dsu_pkg::ST_OK;
                state_next      = S_OUT;
                case (op_reg)
                    dsu_pkg::OP_MAKE:
                    begin
                        if (alloc_reg == CNT_W'(NODE_COUNT))
                        begin
                            res_status_next = dsu_pkg::ST_FULL;
                        end
                        else
                        begin
                            // new root of rank 0
                            par_we        = 1'b1;
                            par_addr      = IDX_W'(alloc_reg);
                            par_data      = IDX_W'(alloc_reg);
                            rank_we       = 1'b1;
                            rank_addr     = IDX_W'(alloc_reg);
                            rank_data     = '0;
                            res_node_next = dsu_pkg::NODE_W'(alloc_reg);
                            alloc_next    = alloc_reg + CNT_W'(1);
                            live_next     = live_reg + CNT_W'(1);
                        end
                    end
                    dsu_pkg::OP_FIND, dsu_pkg::OP_UNION:
                    begin
                        if (a_bad || (op_reg == dsu_pkg::OP_UNION && b_bad))
                        begin
                            res_status_next = dsu_pkg::ST_UNKNOWN;
                        end
                        else
                        begin
                            cur_next   = IDX_W'(a_reg);
                            rd_en      = 1'b1;
                            rd_addr    = IDX_W'(a_reg);
                            state_next = S_WALK_A;
                        end
                    end
                    default:
                    begin
                        res_status_next = dsu_pkg::ST_OK;
                    end
                endcase
            end

            S_WALK_A:
            begin
                if (rd_parent == cur_reg)
                begin
                    root_a_next = cur_reg;
                    rank_a_next = rd_rank;
                    if (op_reg == dsu_pkg::OP_FIND)
                    begin
                        res_node_next = dsu_pkg::NODE_W'(cur_reg);
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        cur_next   = IDX_W'(b_reg);
                        rd_en      = 1'b1;
                        rd_addr    = IDX_W'(b_reg);
                        state_next = S_WALK_B;
                    end
                end
                else
                begin
                    cur_next = rd_parent;
                    rd_en    = 1'b1;
                    rd_addr  = rd_parent;
                end
            end

            S_WALK_B:
            begin
                if (rd_parent == cur_reg)
                begin
                    state_next = S_OUT;
                    if (cur_reg == root_a_reg)
                    begin
                        // already one set
                        res_node_next = dsu_pkg::NODE_W'(root_a_reg);
                    end
                    else if (rank_a_reg < rd_rank)
                    begin
                        par_we        = 1'b1;
                        par_addr      = root_a_reg;
                        par_data      = cur_reg;
                        res_node_next = dsu_pkg::NODE_W'(cur_reg);
                        live_next     = live_reg - CNT_W'(1);
                    end
                    else
                    begin
                        par_we        = 1'b1;
                        par_addr      = cur_reg;
                        par_data      = root_a_reg;
                        res_node_next = dsu_pkg::NODE_W'(root_a_reg);
                        live_next     = live_reg - CNT_W'(1);
                        // equal ranks: survivor grows, saturating
                        if (rank_a_reg == rd_rank && rank_a_reg != dsu_pkg::RANK_MAX)
                        begin
                            rank_we   = 1'b1;
                            rank_addr = root_a_reg;
                            rank_data = rank_a_reg + RANK_W'(1);
                        end
                    end
                end
                else
                begin
                    cur_next = rd_parent;
                    rd_en    = 1'b1;
                    rd_addr  = rd_parent;
                end
            end

            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_node_next   = out_node_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_node_next   = res_node_reg;
            out_count_next  = dsu_pkg::SET_W'(live_reg);
            out_status_next = res_status_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            alloc_reg     <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            alloc_reg     <= alloc_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        cur_reg        <= cur_next;
        root_a_reg     <= root_a_next;
        rank_a_reg     <= rank_a_next;
        res_node_reg   <= res_node_next;
        res_status_reg <= res_status_next;
        out_node_reg   <= out_node_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

endmodule

// ===== design/dsu_store.sv =====
// ----------------------------------------------------------------------------
// dsu_store
// Parent and rank memories: one read port shared by both, one write port each,
// read data registered.
// ----------------------------------------------------------------------------
module dsu_store #(
    parameter int NODE_COUNT = dsu_pkg::NODE_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rd_en,
    input  logic [$clog2(NODE_COUNT)-1:0]   rd_addr,
    output logic [$clog2(NODE_COUNT)-1:0]   rd_parent,
    output logic [dsu_pkg::RANK_W-1:0]      rd_rank,
    input  logic                            par_we,
    input  logic [$clog2(NODE_COUNT)-1:0]   par_addr,
    input  logic [$clog2(NODE_COUNT)-1:0]   par_data,
    input  logic                            rank_we,
    input  logic [$clog2(NODE_COUNT)-1:0]   rank_addr,
    input  logic [dsu_pkg::RANK_W-1:0]      rank_data
);

    localparam int IDX_W = $clog2(NODE_COUNT);

    logic [IDX_W-1:0]           parent_mem [NODE_COUNT];
    logic [dsu_pkg::RANK_W-1:0] rank_mem   [NODE_COUNT];

    // Parent links
    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            parent_mem[par_addr] <= par_data;
        end
        if (rd_en)
        begin
            rd_parent <= parent_mem[rd_addr];
        end
    end

    // Root ranks
    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[rank_addr] <= rank_data;
        end
        if (rd_en)
        begin
            rd_rank <= rank_mem[rd_addr];
        end
    end

endmodule
